@@ rtl/core/cprc_pkg.sv @@
// shared types, codes and constants for the camera pixel to rgb converter
package cprc_pkg;

   localparam int MAX_WIDTH_DEF = 2048;
   localparam int MAX_HEIGHT    = 4096;
   localparam int FWIDTH_W      = 12;
   localparam int HEIGHT_W      = 13;
   localparam int LINE_W        = 12;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 13;
   localparam int ACC_W         = 20;

   typedef logic [2:0] src_fmt_type;
   localparam src_fmt_type SRC_BGR24  = 3'd0;
   localparam src_fmt_type SRC_RGB24  = 3'd1;
   localparam src_fmt_type SRC_BGR32  = 3'd2;
   localparam src_fmt_type SRC_RGB32  = 3'd3;
   localparam src_fmt_type SRC_YUV420 = 3'd4;

   typedef logic [1:0] out_order_type;
   localparam out_order_type ORD_RGB24 = 2'd0;
   localparam out_order_type ORD_BGR24 = 2'd1;
   localparam out_order_type ORD_RGB32 = 2'd2;
   localparam out_order_type ORD_BGR32 = 2'd3;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_SOURCE_FORMAT = 2'd0;
   localparam csr_idx_type CSR_OUTPUT_ORDER  = 2'd1;
   localparam csr_idx_type CSR_FRAME_WIDTH   = 2'd2;
   localparam csr_idx_type CSR_FRAME_HEIGHT  = 2'd3;

   localparam src_fmt_type          RST_SOURCE_FORMAT = SRC_BGR24;
   localparam out_order_type        RST_OUTPUT_ORDER  = ORD_BGR24;
   localparam logic [FWIDTH_W-1:0]  RST_FRAME_WIDTH   = 12'd640;
   localparam logic [HEIGHT_W-1:0]  RST_FRAME_HEIGHT  = 13'd480;

   localparam logic [2:0] BYTES_24 = 3'd3;
   localparam logic [2:0] BYTES_32 = 3'd4;

   // 8.8 fixed-point coefficients
   localparam logic signed [ACC_W-1:0] K_RV = 20'sd359;
   localparam logic signed [ACC_W-1:0] K_GU = 20'sd88;
   localparam logic signed [ACC_W-1:0] K_GV = 20'sd183;
   localparam logic signed [ACC_W-1:0] K_BU = 20'sd454;
   localparam logic signed [8:0]       CHROMA_BIAS = 9'sd128;
   localparam logic signed [ACC_W-1:0] CH_MAX = 20'sd255;

   typedef struct packed {
      src_fmt_type           source_format;
      out_order_type         output_order;
      logic [FWIDTH_W-1:0]   frame_width;
      logic [HEIGHT_W-1:0]   frame_height;
   } cfg_type;

   typedef struct packed {
      logic eol;
      logic eof;
   } pos_type;

endpackage

@@ rtl/core/cprc_csr.sv @@
// configuration registers of the converter
module cprc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  cprc_pkg::csr_idx_type           csr_index,
   input  logic [cprc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output cprc_pkg::cfg_type               cfg
);
   import cprc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_SOURCE_FORMAT: cfg_in.source_format = csr_wdata[2:0];
            CSR_OUTPUT_ORDER:  cfg_in.output_order  = csr_wdata[1:0];
            CSR_FRAME_WIDTH:   cfg_in.frame_width   = csr_wdata[FWIDTH_W-1:0];
            CSR_FRAME_HEIGHT:  cfg_in.frame_height  = csr_wdata[HEIGHT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.source_format <= RST_SOURCE_FORMAT;
         cfg_ff.output_order  <= RST_OUTPUT_ORDER;
         cfg_ff.frame_width   <= RST_FRAME_WIDTH;
         cfg_ff.frame_height  <= RST_FRAME_HEIGHT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/cprc_seq.sv @@
// raster position counters and chroma tracking with the chroma line store
module cprc_seq #(
   parameter int MAX_WIDTH = cprc_pkg::MAX_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        req_comp1,
   input  logic [7:0]        req_comp2,
   input  logic              req_chroma_present,
   input  cprc_pkg::cfg_type cfg,
   output cprc_pkg::pos_type pos,
   output logic [15:0]       chroma
);
   import cprc_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int DEPTH  = (MAX_WIDTH + 1) / 2;
   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WLIM_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = ((WLIM_W > FWIDTH_W) ? WLIM_W : FWIDTH_W) + 1;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [LINE_W-1:0]  line_ff, line_in;
   logic [15:0]        chroma_ff, chroma_in;
   logic               last_mem_ff, last_mem_in;
   logic [15:0]        mem_q_ff;
   logic [15:0]        chroma_mem [DEPTH];

   logic [CMP_W-1:0]    fw, wmax, w_eff, col_next;
   logic [HEIGHT_W-1:0] h_eff, line_next;
   logic [SLOT_W-1:0]   slot;
   logic                yuv, load_new, load_mem;

   // clamped frame size
   always_comb begin
      fw   = CMP_W'(cfg.frame_width);
      wmax = CMP_W'(MAX_WIDTH);
      if (fw < CMP_W'(2)) begin
         w_eff = CMP_W'(2);
      end else if (fw > wmax) begin
         w_eff = wmax;
      end else begin
         w_eff = fw;
      end
      if (cfg.frame_height == '0) begin
         h_eff = HEIGHT_W'(1);
      end else if (cfg.frame_height > HEIGHT_W'(MAX_HEIGHT)) begin
         h_eff = HEIGHT_W'(MAX_HEIGHT);
      end else begin
         h_eff = cfg.frame_height;
      end
   end

   assign col_next  = CMP_W'(col_ff) + CMP_W'(1);
   assign line_next = HEIGHT_W'(line_ff) + HEIGHT_W'(1);
   assign pos.eol   = (col_next >= w_eff);
   assign pos.eof   = pos.eol && (line_next >= h_eff);

   always_comb begin
      col_in  = col_ff;
      line_in = line_ff;
      if (accept) begin
         if (pos.eol) begin
            col_in  = '0;
            line_in = pos.eof ? '0 : LINE_W'(line_next);
         end else begin
            col_in  = COL_W'(col_next);
         end
      end
   end

   // even lines fill the store, odd lines read it back
   assign slot     = SLOT_W'(col_ff >> 1);
   assign yuv      = (cfg.source_format == SRC_YUV420);
   assign load_new = yuv && !col_ff[0] && !line_ff[0];
   assign load_mem = yuv && !col_ff[0] && line_ff[0];

   // chroma after the last accepted pixel
   assign chroma = last_mem_ff ? mem_q_ff : chroma_ff;

   always_comb begin
      chroma_in   = chroma_ff;
      last_mem_in = last_mem_ff;
      if (accept) begin
         chroma_in   = (load_new && req_chroma_present) ? {req_comp1, req_comp2} : chroma;
         last_mem_in = load_mem;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         line_ff     <= '0;
         chroma_ff   <= '0;
         last_mem_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         line_ff     <= line_in;
         chroma_ff   <= chroma_in;
         last_mem_ff <= last_mem_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && load_new) begin
         chroma_mem[slot] <= chroma_in;
      end
      if (accept && load_mem) begin
         mem_q_ff <= chroma_mem[slot];
      end
   end

endmodule

@@ rtl/core/cprc_color.sv @@
// color conversion, channel clamp and output byte ordering
module cprc_color (
   input  logic              [7:0] comp0,
   input  logic              [7:0] comp1,
   input  logic              [7:0] comp2,
   input  logic             [15:0] chroma,
   input  cprc_pkg::cfg_type       cfg,
   output logic              [7:0] out_byte0,
   output logic              [7:0] out_byte1,
   output logic              [7:0] out_byte2,
   output logic              [7:0] out_byte3,
   output logic              [2:0] byte_count
);
   import cprc_pkg::*;

   function automatic logic [7:0] clamp_channel(input logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] q;
      q = acc >>> 8;
      if (q < 0) begin
         return 8'd0;
      end else if (q > CH_MAX) begin
         return 8'd255;
      end
      return q[7:0];
   endfunction

   logic signed [8:0]       u_s, v_s;
   logic signed [ACC_W-1:0] y_term, u_ext, v_ext;
   logic signed [ACC_W-1:0] r_acc, g_acc, b_acc;
   logic [7:0]              r, g, b;

   assign u_s    = $signed({1'b0, chroma[15:8]}) - CHROMA_BIAS;
   assign v_s    = $signed({1'b0, chroma[7:0]}) - CHROMA_BIAS;
   assign y_term = $signed({4'b0000, comp0, 8'h00});
   assign u_ext  = {{(ACC_W-9){u_s[8]}}, u_s};
   assign v_ext  = {{(ACC_W-9){v_s[8]}}, v_s};
   assign r_acc  = y_term + v_ext * K_RV;
   assign g_acc  = y_term - u_ext * K_GU - v_ext * K_GV;
   assign b_acc  = y_term + u_ext * K_BU;

   always_comb begin
      unique case (cfg.source_format)
         SRC_YUV420: begin
            r = clamp_channel(r_acc);
            g = clamp_channel(g_acc);
            b = clamp_channel(b_acc);
         end
         SRC_RGB24, SRC_RGB32: begin
            r = comp0;
            g = comp1;
            b = comp2;
         end
         SRC_BGR24, SRC_BGR32: begin
            b = comp0;
            g = comp1;
            r = comp2;
         end
         // unused codes behave as bgr24
         default: begin
            b = comp0;
            g = comp1;
            r = comp2;
         end
      endcase
   end

   always_comb begin
      unique case (cfg.output_order)
         ORD_RGB24, ORD_RGB32: begin
            out_byte0 = r;
            out_byte2 = b;
         end
         default: begin
            out_byte0 = b;
            out_byte2 = r;
         end
      endcase
      out_byte1  = g;
      out_byte3  = 8'd0;
      byte_count = (cfg.output_order == ORD_RGB32 || cfg.output_order == ORD_BGR32)
                   ? BYTES_32 : BYTES_24;
   end

endmodule

@@ rtl/core/camera_pixel_to_rgb_converter.sv @@
// Camera pixel to packed RGB converter, top level.
//
// Input transactions (req_*) carry one pixel in raster order: three source
// bytes and, for YUV 4:2:0, a flag that marks new U/V on even columns of
// even lines. Output transactions (rsp_*) carry one packed pixel with its
// byte count and end-of-line / end-of-frame marks. Both channels move a
// transaction at a clock edge with valid high and stall low.
// The csr_* port writes the four configuration registers; csr_ready is
// always high. Write it only while no pixel is in flight.
// rsp_valid rises once the pixel has passed the input register, where the
// chroma line store read completes, and the output register, which the
// color math loads. One pixel per cycle sustained while the receiver does
// not stall.
// When the receiver stalls, the output register holds its pixel and one
// more pixel waits in the input register; only then is req_stall raised.
// Synchronous reset empties both registers, clears the line and column
// counters and chroma, and loads the register defaults. The line store
// needs no clearing; a line is always written before it is read back.
module camera_pixel_to_rgb_converter #(
   parameter int MAX_WIDTH = cprc_pkg::MAX_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_comp0,
   input  logic [7:0]                      req_comp1,
   input  logic [7:0]                      req_comp2,
   input  logic                            req_chroma_present,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_out_byte0,
   output logic [7:0]                      rsp_out_byte1,
   output logic [7:0]                      rsp_out_byte2,
   output logic [7:0]                      rsp_out_byte3,
   output logic [2:0]                      rsp_byte_count,
   output logic                            rsp_end_of_line,
   output logic                            rsp_end_of_frame,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  cprc_pkg::csr_idx_type           csr_index,
   input  logic [cprc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import cprc_pkg::*;

   cfg_type     cfg;
   pos_type     pos;
   logic [15:0] chroma;

   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_comp0_ff, s1_comp1_ff, s1_comp2_ff;
   pos_type     s1_pos_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_byte0_ff, rsp_byte1_ff, rsp_byte2_ff, rsp_byte3_ff;
   logic [2:0]  rsp_count_ff;
   pos_type     rsp_pos_ff;

   logic [7:0]  cv_byte0, cv_byte1, cv_byte2, cv_byte3;
   logic [2:0]  cv_count;
   logic        out_free, s1_adv, accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   cprc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   cprc_seq #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_seq (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .req_comp1          (req_comp1),
      .req_comp2          (req_comp2),
      .req_chroma_present (req_chroma_present),
      .cfg                (cfg),
      .pos                (pos),
      .chroma             (chroma)
   );

   cprc_color u_color (
      .comp0      (s1_comp0_ff),
      .comp1      (s1_comp1_ff),
      .comp2      (s1_comp2_ff),
      .chroma     (chroma),
      .cfg        (cfg),
      .out_byte0  (cv_byte0),
      .out_byte1  (cv_byte1),
      .out_byte2  (cv_byte2),
      .out_byte3  (cv_byte3),
      .byte_count (cv_count)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_comp0_ff <= req_comp0;
         s1_comp1_ff <= req_comp1;
         s1_comp2_ff <= req_comp2;
         s1_pos_ff   <= pos;
      end
      if (s1_adv) begin
         rsp_byte0_ff <= cv_byte0;
         rsp_byte1_ff <= cv_byte1;
         rsp_byte2_ff <= cv_byte2;
         rsp_byte3_ff <= cv_byte3;
         rsp_count_ff <= cv_count;
         rsp_pos_ff   <= s1_pos_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte0    = rsp_byte0_ff;
   assign rsp_out_byte1    = rsp_byte1_ff;
   assign rsp_out_byte2    = rsp_byte2_ff;
   assign rsp_out_byte3    = rsp_byte3_ff;
   assign rsp_byte_count   = rsp_count_ff;
   assign rsp_end_of_line  = rsp_pos_ff.eol;
   assign rsp_end_of_frame = rsp_pos_ff.eof;

endmodule

@@ rtl/core/cprc_checker.sv @@
// port-level checks for the converter, bound to the top level
module cprc_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_byte0,
   input logic [7:0] rsp_out_byte1,
   input logic [7:0] rsp_out_byte2,
   input logic [7:0] rsp_out_byte3,
   input logic [2:0] rsp_byte_count,
   input logic       rsp_end_of_line,
   input logic       rsp_end_of_frame
);
   import cprc_pkg::*;

   // a stalled output transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte0)
         && $stable(rsp_out_byte1) && $stable(rsp_out_byte2)
         && $stable(rsp_byte_count) && $stable(rsp_end_of_frame))
      else $error("stalled output transaction changed");

   a_eof_eol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_frame |-> rsp_end_of_line)
      else $error("end of frame without end of line");

   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count == BYTES_24 || rsp_byte_count == BYTES_32))
      else $error("bad byte count");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_byte3 == 8'd0)
      else $error("pad byte not zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid right after reset");

endmodule

bind camera_pixel_to_rgb_converter cprc_checker u_checker (.*);
